FILE: hdl/ecs_pkg.sv
package ecs_pkg;

  // millisecond counters and configuration registers
  localparam int unsigned CntW = 16;
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
  localparam logic [CntW-1:0] DebounceMsReset = 16'd20;
  localparam logic [CntW-1:0] BlinkHalfMsReset = 16'd250;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgDebounceMs = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBlinkHalfMs = 2'd1;

  // color codes
  localparam int unsigned ColorW = 3;
  localparam logic [ColorW-1:0] ColorOff = 3'd0;
  localparam logic [ColorW-1:0] ColorRed = 3'd1;
  localparam logic [ColorW-1:0] ColorGreen = 3'd2;
  localparam logic [ColorW-1:0] ColorBlue = 3'd3;
  localparam logic [ColorW-1:0] ColorWhite = 3'd4;

  // encoder pin states
  localparam logic [1:0] EncIdle = 2'b11;

  // sample of the pins held in the input register
  typedef struct packed {
    logic [1:0] enc;
    logic       button_level;
    logic       ms_tick;
  } sample_t;

  // debouncer report for the current sample
  typedef struct packed {
    logic press;
  } button_ev_t;

  // encoder report for the current sample
  typedef struct packed {
    logic up;
    logic down;
  } enc_step_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == CntMax) ? CntMax : v + 1'b1;
  endfunction

endpackage

FILE: hdl/ecs_in_if.sv
interface ecs_in_if;
  logic valid;
  logic ready;
  logic enc_a;
  logic enc_b;
  logic button_level;
  logic ms_tick;

  modport source (output valid, enc_a, enc_b, button_level, ms_tick, input ready);
  modport sink (input valid, enc_a, enc_b, button_level, ms_tick, output ready);
endinterface

FILE: hdl/ecs_out_if.sv
interface ecs_out_if;
  logic       valid;
  logic       ready;
  logic       red_on;
  logic       green_on;
  logic       blue_on;
  logic [2:0] color_index;
  logic       select_mode;

  modport source (output valid, red_on, green_on, blue_on, color_index, select_mode,
                  input ready);
  modport sink (input valid, red_on, green_on, blue_on, color_index, select_mode,
                output ready);
endinterface

FILE: hdl/ecs_debounce.sv
module ecs_debounce (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  ecs_pkg::sample_t         sample_i,
  input  logic [ecs_pkg::CntW-1:0] debounce_ms_i,
  output ecs_pkg::button_ev_t      ev_o
);
  import ecs_pkg::*;

  logic            last_raw_q, last_raw_d;
  logic            deb_q, deb_d;
  logic [CntW-1:0] since_q, since_d;
  logic            accept;

  // count held time, restart on a raw level change, accept a stable new level
  always_comb begin
    since_d = sample_i.ms_tick ? sat_inc(since_q) : since_q;
    last_raw_d = last_raw_q;
    if (sample_i.button_level != last_raw_q) begin
      since_d = '0;
      last_raw_d = sample_i.button_level;
    end
    accept = (since_d >= debounce_ms_i) && (deb_q != sample_i.button_level);
    deb_d = accept ? sample_i.button_level : deb_q;
    ev_o.press = accept && !sample_i.button_level;
  end

  // advance on each request that moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= 1'b1;
      deb_q <= 1'b1;
      since_q <= '0;
    end else if (adv_i) begin
      last_raw_q <= last_raw_d;
      deb_q <= deb_d;
      since_q <= since_d;
    end
  end

endmodule

FILE: hdl/ecs_encoder.sv
module ecs_encoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic [1:0]         enc_i,
  input  logic               locked_i,
  input  logic               toggle_i,
  output ecs_pkg::enc_step_t step_o
);
  import ecs_pkg::*;

  logic [1:0]        last_q;
  logic signed [1:0] count_q, count_d;
  logic signed [2:0] dir;
  logic signed [2:0] sum;

  // decode one quarter step from the previous and current pin states
  always_comb begin
    case ({last_q, enc_i})
      4'b0001, 4'b0111, 4'b1110, 4'b1000: dir = -3'sd1;
      4'b0010, 4'b1011, 4'b1101, 4'b0100: dir = 3'sd1;
      default:                            dir = 3'sd0;
    endcase
  end

  // accumulate while unlocked, emit a color step on two quarter steps
  always_comb begin
    sum = 3'(count_q) + dir;
    step_o.up = 1'b0;
    step_o.down = 1'b0;
    count_d = count_q;
    if (toggle_i) begin
      count_d = '0;
    end else if (!locked_i) begin
      if (sum == 3'sd2) begin
        step_o.up = 1'b1;
        count_d = '0;
      end else if (sum == -3'sd2) begin
        step_o.down = 1'b1;
        count_d = '0;
      end else begin
        count_d = sum[1:0];
      end
    end
  end

  // store the pin state on every request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= EncIdle;
      count_q <= '0;
    end else if (adv_i) begin
      last_q <= enc_i;
      count_q <= count_d;
    end
  end

endmodule

FILE: hdl/encoder_color_selector.sv
// Rotary color chooser: each request carries one sample of the quadrature pins, the
// active-low button and a millisecond tick, and yields one result with the RGB drive,
// the color index and the select flag. A request is taken every clock cycle; its
// result passes through the input register and then the result register, and
// back-pressure on the result side stalls the input side only once both registers
// hold data. Outside select mode two quarter steps move the color, a debounced press
// with a color set toggles select mode, which blinks the LEDs with half period blink_half_ms.
// Configuration: index 0 debounce_ms, index 1 blink_half_ms; write only when idle.
module encoder_color_selector (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ecs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ecs_pkg::CntW-1:0]    cfg_data_i,
  ecs_in_if.sink                      in_i,
  ecs_out_if.source                   out_o
);
  import ecs_pkg::*;

  logic            s1_v_q;
  sample_t         s1_q;
  logic            out_v_q;
  logic            out_free, s1_adv;

  logic [CntW-1:0] debounce_ms_q, blink_half_ms_q;

  logic [ColorW-1:0] color_q, color_d;
  logic              locked_q, locked_d;
  logic              phase_q, phase_d;
  logic [CntW-1:0]   since_blink_q, since_blink_d;
  logic              toggle;
  logic [ColorW-1:0] show;

  button_ev_t btn_ev;
  enc_step_t  enc_step;

  logic              red_q, green_q, blue_q, select_q;
  logic [ColorW-1:0] color_out_q;

  // handshake: input register refills while the result register drains
  assign out_free = !out_v_q || out_o.ready;
  assign s1_adv = s1_v_q && out_free;
  assign in_i.ready = !s1_v_q || out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ms_q <= DebounceMsReset;
      blink_half_ms_q <= BlinkHalfMsReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDebounceMs:  debounce_ms_q <= cfg_data_i;
        CfgBlinkHalfMs: blink_half_ms_q <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q.enc <= {in_i.enc_a, in_i.enc_b};
      s1_q.button_level <= in_i.button_level;
      s1_q.ms_tick <= in_i.ms_tick;
    end
  end

  ecs_debounce u_debounce (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (s1_adv),
    .sample_i      (s1_q),
    .debounce_ms_i (debounce_ms_q),
    .ev_o          (btn_ev)
  );

  assign toggle = btn_ev.press && (color_q != ColorOff);

  ecs_encoder u_encoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (s1_adv),
    .enc_i    (s1_q.enc),
    .locked_i (locked_q),
    .toggle_i (toggle),
    .step_o   (enc_step)
  );

  // color, lock and blink update
  always_comb begin
    locked_d = locked_q ^ toggle;
    since_blink_d = s1_q.ms_tick ? sat_inc(since_blink_q) : since_blink_q;
    phase_d = phase_q;
    if (toggle) begin
      since_blink_d = '0;
      phase_d = 1'b0;
    end
    color_d = color_q;
    if (enc_step.up) begin
      color_d = (color_q >= ColorWhite) ? ColorOff : color_q + 1'b1;
    end else if (enc_step.down) begin
      color_d = (color_q == ColorOff) ? ColorWhite : color_q - 1'b1;
    end
    if (locked_d && (since_blink_d >= blink_half_ms_q)) begin
      since_blink_d = '0;
      phase_d = !phase_d;
    end
    show = (!locked_d || phase_d) ? color_d : ColorOff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= ColorOff;
      locked_q <= 1'b0;
      phase_q <= 1'b0;
      since_blink_q <= '0;
    end else if (s1_adv) begin
      color_q <= color_d;
      locked_q <= locked_d;
      phase_q <= phase_d;
      since_blink_q <= since_blink_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_adv) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      red_q <= (show == ColorRed) || (show == ColorWhite);
      green_q <= (show == ColorGreen) || (show == ColorWhite);
      blue_q <= (show == ColorBlue) || (show == ColorWhite);
      color_out_q <= color_d;
      select_q <= locked_d;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.red_on = red_q;
  assign out_o.green_on = green_q;
  assign out_o.blue_on = blue_q;
  assign out_o.color_index = color_out_q;
  assign out_o.select_mode = select_q;

endmodule
